@@ rtl/core/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared codes for the source text tokenizer
// result kinds, scan mode codes, character constants and character classes
// ----------------------------------------------------------------------------
package stt_pkg;

  // result kinds
  localparam logic [2:0] KIND_INT     = 3'd0;
  localparam logic [2:0] KIND_FLOAT   = 3'd1;
  localparam logic [2:0] KIND_SYMBOL  = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_PAYLOAD = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  // error codes
  localparam logic ERR_INVALID_CHAR = 1'b0;
  localparam logic ERR_UNTERMINATED = 1'b1;

  // scan mode codes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_NUMBER  = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_ESCAPE  = 3'd4;
  localparam logic [2:0] MODE_PENDING = 3'd5;

  // register indexes
  localparam logic REG_PAIR_FIRST  = 1'b0;
  localparam logic REG_PAIR_SECOND = 1'b1;

  localparam logic [15:0] PAIR_FIRST_RESET  = 16'h403D;
  localparam logic [15:0] PAIR_SECOND_RESET = 16'h3A3D;

  localparam logic [30:0]   VALUE_MAX  = 31'h7FFF_FFFF;

  // characters
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_LOWER_N    = 8'h6E;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // punctuation set: all printable non-alphanumerics except the space and the double quote
  function automatic logic is_symbol(input logic [7:0] c);
    return (c == 8'h21) ||
           ((c >= 8'h23) && (c <= 8'h2F)) ||
           ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) ||
           ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

endpackage

@@ rtl/core/source_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit: streaming lexical tokenizer
// one source character per item in, token, payload and error results out
// ----------------------------------------------------------------------------
// - slave stream: s_axis_tdata[7:0] is the source char; s_axis_tlast ends the
//   source (char ignored), restarts positions at line 1, column 1 and,
//   unless halted or in a string, flushes pending token and sends end token
// - master stream: m_axis_tuser is the result kind, m_axis_tlast marks the
//   final result caused by one input item
// - apb: register 0 at address 0 and register 1 at address 4 hold the two
//   combined symbols (high byte first); write only while the block is idle
// - flow: an accepted item is scanned out of the input register into the
//   4-entry result queue, and its results go out from the queue head
// - throughput: one item per cycle while the receiver keeps up and the queue
//   has room for two results; the queue drains one result per ready cycle
// - the input register advances only with room for two results queued; a
//   stalled receiver fills the queue and then holds tready low
// - reset empties the queue and input register, loads the default pairs and
//   returns the scanner to line 1, column 1 with no token pending
module source_text_tokenizer_unit #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // source stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  input  logic        s_axis_tlast,   // end_of_source

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // token_line, token_column, int_value, int_saturated, symbol_first,
  // symbol_second, payload_char, error_code, zero fill
  output logic [((LINE_BITS + COLUMN_BITS + 57 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last_of_run

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OUT_BITS = ((LINE_BITS + COLUMN_BITS + 57 + 7) / 8) * 8;
  localparam int unsigned DEPTH    = 4;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [2:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [30:0]            int_value;
    logic                   int_sat;
    logic [7:0]             sym_first;
    logic [7:0]             sym_second;
    logic [7:0]             pay_char;
    logic                   err_code;
    logic                   last;
  } result_t;

  function automatic result_t mk_result(input logic [2:0] kind,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic [COLUMN_BITS-1:0] column);
    result_t r;
    r        = '0;
    r.kind   = kind;
    r.line   = line;
    r.column = column;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] pair_first_q, pair_second_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // byte lanes below the word address are not decoded
  assign prdata = (paddr[2] == stt_pkg::REG_PAIR_SECOND) ? {16'h0000, pair_second_q}
                                                          : {16'h0000, pair_first_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_first_q  <= stt_pkg::PAIR_FIRST_RESET;
      pair_second_q <= stt_pkg::PAIR_SECOND_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == stt_pkg::REG_PAIR_FIRST) begin
        pair_first_q <= pwdata[15:0];
      end else begin
        pair_second_q <= pwdata[15:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic          in_valid_q;
  logic [7:0]    in_char_q;
  logic          in_last_q;
  logic          consume;
  logic [CNT_BITS-1:0] count_q, count_d;

  // room for two results, judged on the registered fill only
  assign consume       = in_valid_q && (count_q <= CNT_BITS'(DEPTH - 2));
  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // scanner state
  // ---------------------------------------------------------------------------
  logic [2:0]             mode_q, mode_d;
  logic                   saw_dot_q, saw_dot_d;
  logic [30:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [7:0]             held_q, held_d;
  logic [LINE_BITS-1:0]   start_line_q, start_line_d, cur_line_q, cur_line_d;
  logic [COLUMN_BITS-1:0] start_col_q, start_col_d, cur_col_q, cur_col_d;
  logic                   halted_q, halted_d;

  result_t    res_a, res_b, flush_res, out0, out1;
  logic       a_v, b_v, flush_v;
  logic       run_idle, do_flush, newline;
  logic [34:0] acc_next;
  logic [1:0]  push_n;
  logic [7:0]  c;

  assign c        = in_char_q;
  // acc*10 + digit, checked against the 31-bit ceiling
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                    {31'd0, c[3:0] - stt_pkg::CHAR_ZERO[3:0]};

  always_comb begin
    mode_d       = mode_q;
    saw_dot_d    = saw_dot_q;
    acc_d        = acc_q;
    ovf_d        = ovf_q;
    held_d       = held_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    halted_d     = halted_q;
    res_a        = '0;
    res_b        = '0;
    a_v          = 1'b0;
    b_v          = 1'b0;
    run_idle     = 1'b0;
    do_flush     = 1'b0;
    newline      = 1'b0;

    // token closed by whatever ends the current run
    flush_res = '0;
    flush_v   = 1'b0;
    case (mode_q)
      stt_pkg::MODE_NUMBER: begin
        flush_v = 1'b1;
        if (saw_dot_q) begin
          flush_res = mk_result(stt_pkg::KIND_FLOAT, start_line_q, start_col_q);
        end else begin
          flush_res           = mk_result(stt_pkg::KIND_INT, start_line_q, start_col_q);
          flush_res.int_value = acc_q;
          flush_res.int_sat   = ovf_q;
        end
      end
      stt_pkg::MODE_IDENT: begin
        flush_v   = 1'b1;
        flush_res = mk_result(stt_pkg::KIND_IDENT, start_line_q, start_col_q);
      end
      stt_pkg::MODE_PENDING: begin
        flush_v             = 1'b1;
        flush_res           = mk_result(stt_pkg::KIND_SYMBOL, start_line_q, start_col_q);
        flush_res.sym_first = held_q;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase

    if (in_last_q) begin
      if (halted_q) begin
        halted_d = 1'b0;
      end else if (mode_q == stt_pkg::MODE_STRING || mode_q == stt_pkg::MODE_ESCAPE) begin
        a_v            = 1'b1;
        res_a          = mk_result(stt_pkg::KIND_ERROR, start_line_q, start_col_q);
        res_a.err_code = stt_pkg::ERR_UNTERMINATED;
      end else begin
        a_v   = flush_v;
        res_a = flush_res;
        b_v   = 1'b1;
        res_b = mk_result(stt_pkg::KIND_END, cur_line_q, cur_col_q);
      end
      mode_d       = stt_pkg::MODE_IDLE;
      saw_dot_d    = 1'b0;
      acc_d        = '0;
      ovf_d        = 1'b0;
      held_d       = '0;
      start_line_d = LINE_BITS'(1);
      start_col_d  = COLUMN_BITS'(1);
      cur_line_d   = LINE_BITS'(1);
      cur_col_d    = COLUMN_BITS'(1);
    end else if (!halted_q) begin
      case (mode_q)
        stt_pkg::MODE_NUMBER: begin
          if (stt_pkg::is_digit(c) || c == stt_pkg::CHAR_DOT) begin
            if (c == stt_pkg::CHAR_DOT) begin
              saw_dot_d = 1'b1;
            end else if (acc_next > {4'd0, stt_pkg::VALUE_MAX}) begin
              acc_d = stt_pkg::VALUE_MAX;
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_next[30:0];
            end
            a_v            = 1'b1;
            res_a          = mk_result(stt_pkg::KIND_PAYLOAD, start_line_q, start_col_q);
            res_a.pay_char = c;
          end else begin
            do_flush = 1'b1;
            run_idle = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_alpha(c) || c == stt_pkg::CHAR_UNDERSCORE) begin
            a_v            = 1'b1;
            res_a          = mk_result(stt_pkg::KIND_PAYLOAD, start_line_q, start_col_q);
            res_a.pay_char = c;
          end else begin
            do_flush = 1'b1;
            run_idle = 1'b1;
          end
        end
        stt_pkg::MODE_PENDING: begin
          if ({held_q, c} == pair_first_q || {held_q, c} == pair_second_q) begin
            a_v              = 1'b1;
            res_a            = mk_result(stt_pkg::KIND_SYMBOL, start_line_q, start_col_q);
            res_a.sym_first  = held_q;
            res_a.sym_second = c;
            mode_d           = stt_pkg::MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            run_idle = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (c == stt_pkg::CHAR_QUOTE) begin
            a_v    = 1'b1;
            res_a  = mk_result(stt_pkg::KIND_STRING, start_line_q, start_col_q);
            mode_d = stt_pkg::MODE_IDLE;
          end else if (c == stt_pkg::CHAR_BACKSLASH) begin
            mode_d = stt_pkg::MODE_ESCAPE;
          end else begin
            a_v            = 1'b1;
            res_a          = mk_result(stt_pkg::KIND_PAYLOAD, start_line_q, start_col_q);
            res_a.pay_char = c;
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          mode_d         = stt_pkg::MODE_STRING;
          a_v            = 1'b1;
          res_a          = mk_result(stt_pkg::KIND_PAYLOAD, start_line_q, start_col_q);
          res_a.pay_char = c;
          if (c == stt_pkg::CHAR_LOWER_N) begin
            res_a.pay_char = stt_pkg::CHAR_NEWLINE;
          end else if (c != stt_pkg::CHAR_BACKSLASH && c != stt_pkg::CHAR_QUOTE) begin
            // unknown escape keeps the backslash and the char
            res_a.pay_char = stt_pkg::CHAR_BACKSLASH;
            b_v            = 1'b1;
            res_b          = mk_result(stt_pkg::KIND_PAYLOAD, start_line_q, start_col_q);
            res_b.pay_char = c;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (do_flush) begin
        a_v    = flush_v;
        res_a  = flush_res;
        mode_d = stt_pkg::MODE_IDLE;
      end

      // fresh scan of the char from the idle mode, result goes second
      if (run_idle) begin
        mode_d = stt_pkg::MODE_IDLE;
        if (stt_pkg::is_digit(c)) begin
          mode_d         = stt_pkg::MODE_NUMBER;
          saw_dot_d      = 1'b0;
          ovf_d          = 1'b0;
          acc_d          = {27'd0, c[3:0] - stt_pkg::CHAR_ZERO[3:0]};
          start_line_d   = cur_line_q;
          start_col_d    = cur_col_q;
          b_v            = 1'b1;
          res_b          = mk_result(stt_pkg::KIND_PAYLOAD, cur_line_q, cur_col_q);
          res_b.pay_char = c;
        end else if (stt_pkg::is_symbol(c)) begin
          start_line_d = cur_line_q;
          start_col_d  = cur_col_q;
          if (c == pair_first_q[15:8] || c == pair_second_q[15:8]) begin
            held_d = c;
            mode_d = stt_pkg::MODE_PENDING;
          end else begin
            b_v             = 1'b1;
            res_b           = mk_result(stt_pkg::KIND_SYMBOL, cur_line_q, cur_col_q);
            res_b.sym_first = c;
          end
        end else if (c == stt_pkg::CHAR_QUOTE) begin
          mode_d       = stt_pkg::MODE_STRING;
          start_line_d = cur_line_q;
          start_col_d  = cur_col_q;
        end else if (stt_pkg::is_alpha(c)) begin
          mode_d         = stt_pkg::MODE_IDENT;
          start_line_d   = cur_line_q;
          start_col_d    = cur_col_q;
          b_v            = 1'b1;
          res_b          = mk_result(stt_pkg::KIND_PAYLOAD, cur_line_q, cur_col_q);
          res_b.pay_char = c;
        end else if (c == stt_pkg::CHAR_SPACE || c == stt_pkg::CHAR_TAB) begin
          b_v = 1'b0;
        end else if (c == stt_pkg::CHAR_NEWLINE) begin
          newline = 1'b1;
        end else begin
          b_v            = 1'b1;
          res_b          = mk_result(stt_pkg::KIND_ERROR, cur_line_q, cur_col_q);
          res_b.err_code = stt_pkg::ERR_INVALID_CHAR;
          halted_d       = 1'b1;
        end
      end

      // saturating position counters
      if (newline) begin
        cur_line_d = (cur_line_q == '1) ? cur_line_q : cur_line_q + LINE_BITS'(1);
        cur_col_d  = COLUMN_BITS'(1);
      end else begin
        cur_col_d  = (cur_col_q == '1) ? cur_col_q : cur_col_q + COLUMN_BITS'(1);
      end
    end

    // pack results in order, mark the final one
    out0      = a_v ? res_a : res_b;
    out1      = res_b;
    out0.last = !(a_v && b_v);
    out1.last = 1'b1;
    push_n    = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= stt_pkg::MODE_IDLE;
      saw_dot_q    <= 1'b0;
      acc_q        <= '0;
      ovf_q        <= 1'b0;
      held_q       <= '0;
      start_line_q <= LINE_BITS'(1);
      start_col_q  <= COLUMN_BITS'(1);
      cur_line_q   <= LINE_BITS'(1);
      cur_col_q    <= COLUMN_BITS'(1);
      halted_q     <= 1'b0;
    end else if (consume) begin
      mode_q       <= mode_d;
      saw_dot_q    <= saw_dot_d;
      acc_q        <= acc_d;
      ovf_q        <= ovf_d;
      held_q       <= held_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      halted_q     <= halted_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  result_t             queue_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0]          push_cnt;
  logic                pop;
  result_t             head;

  assign push_cnt      = consume ? push_n : 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign count_d       = count_q + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = OUT_BITS'({head.err_code, head.pay_char, head.sym_second,
                                    head.sym_first, head.int_sat, head.int_value,
                                    head.column, head.line});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_cnt);
      rd_ptr_q <= rd_ptr_q + PTR_BITS'(pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      queue_q[wr_ptr_q] <= out0;
    end
    if (push_cnt == 2'd2) begin
      queue_q[wr_ptr_q + PTR_BITS'(1)] <= out1;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("result queue overfilled");

  a_halt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (mode_q == stt_pkg::MODE_IDLE))
    else $error("scanner halted with a token in progress");

  a_pending_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == stt_pkg::MODE_PENDING) |-> stt_pkg::is_symbol(held_q))
    else $error("pending mode without a held symbol");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && count_q > CNT_BITS'(DEPTH - 2)))
    else $error("input stalled while the queue had room");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the source text tokenizer
// streams character items through the block under several pair settings and
// checks every result against a cycle-free model of the scanner kept here
// ----------------------------------------------------------------------------
module tb_top;

  localparam int    RANDOM_PER_SETTING = 250;
  localparam int    CALM_ITEMS         = 60;
  localparam int    SETTLE_CYCLES      = 8;
  localparam int    STALL_LIMIT        = 2000;
  localparam int    LONG_HOLD          = 96;
  localparam string SYMBOL_CHARS       = "!#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";
  // opening text: float, identifier with underscore, leading underscore,
  // both forms of a held pair char, escapes in a string
  localparam string OPENING_TEXT       = "1.5 a_b\t_@=@x\n\"\\n\\q\\\"\"";

  // one source item as the driver sends it
  typedef struct packed {
    logic       eos;
    logic [7:0] ch;
  } source_item_t;

  // one result as the block should send it
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [30:0] value;
    logic        clamped;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic [7:0]  text;
    logic        err;
    logic        last;
  } token_result_t;

  logic        clk    = 1'b0;
  logic        rst_n  = 1'b0;

  logic        src_valid = 1'b0;
  logic        src_ready;
  logic [7:0]  src_char  = 8'h00;
  logic        src_eos   = 1'b0;

  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [95:0] res_data;
  logic [2:0]  res_kind;
  logic        res_last;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // scanner model state
  logic [2:0]  scan_mode;
  logic        dot_seen;
  logic [30:0] number_value;
  logic        number_clamped;
  logic [7:0]  held_char;
  logic [15:0] tok_line, tok_col, cur_line, cur_col;
  logic        halted;
  logic [15:0] pair_a, pair_b;

  source_item_t  source_feed[$];
  token_result_t step_results[$];
  token_result_t awaited_results[$];

  // bench bookkeeping
  logic        gaps_on = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          items_taken = 0;
  int          results_taken = 0;
  int          mismatches = 0;
  int          settings_used = 0;
  logic [7:0]  kinds_seen = 8'h00;

  always #6 clk = ~clk;

  source_text_tokenizer_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (src_ready),
    .s_axis_tdata  (src_char),
    .s_axis_tlast  (src_eos),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_kind),
    .m_axis_tlast  (res_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // scanner model
  // --------------------------------------------------------------------------

  function automatic logic is_num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    for (int i = 0; i < SYMBOL_CHARS.len(); i++) begin
      if (SYMBOL_CHARS[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // positions stick at the top instead of wrapping
  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic add_result(logic [2:0] kind, logic [15:0] line, logic [15:0] col,
                            logic [30:0] value, logic sat, logic [7:0] s1,
                            logic [7:0] s2, logic [7:0] txt, logic err);
    token_result_t r;
    r = '{kind, line, col, value, sat, s1, s2, txt, err, 1'b0};
    if (step_results.size() < 2) step_results.push_back(r);
  endtask

  task automatic add_payload(logic [7:0] c);
    add_result(stt_pkg::KIND_PAYLOAD, tok_line, tok_col, '0, 1'b0, '0, '0, c, 1'b0);
  endtask

  task automatic restart_scan();
    scan_mode      = stt_pkg::MODE_IDLE;
    dot_seen       = 1'b0;
    number_value   = '0;
    number_clamped = 1'b0;
    held_char      = '0;
    tok_line       = 16'd1;
    tok_col        = 16'd1;
    cur_line       = 16'd1;
    cur_col        = 16'd1;
  endtask

  // finished number, identifier or held symbol becomes its token
  task automatic close_token();
    case (scan_mode)
      stt_pkg::MODE_NUMBER: begin
        if (dot_seen)
          add_result(stt_pkg::KIND_FLOAT, tok_line, tok_col, '0, 1'b0, '0, '0, '0, 1'b0);
        else
          add_result(stt_pkg::KIND_INT, tok_line, tok_col, number_value, number_clamped,
                     '0, '0, '0, 1'b0);
      end
      stt_pkg::MODE_IDENT:
        add_result(stt_pkg::KIND_IDENT, tok_line, tok_col, '0, 1'b0, '0, '0, '0, 1'b0);
      stt_pkg::MODE_PENDING:
        add_result(stt_pkg::KIND_SYMBOL, tok_line, tok_col, '0, 1'b0, held_char, '0, '0,
                   1'b0);
      default: ;
    endcase
    scan_mode = stt_pkg::MODE_IDLE;
  endtask

  // a char seen with no token open
  task automatic scan_fresh(input logic [7:0] c, output logic is_newline);
    is_newline = 1'b0;
    scan_mode  = stt_pkg::MODE_IDLE;
    if (is_num_char(c)) begin
      scan_mode      = stt_pkg::MODE_NUMBER;
      dot_seen       = 1'b0;
      number_clamped = 1'b0;
      number_value   = 31'(c - stt_pkg::CHAR_ZERO);
      tok_line       = cur_line;
      tok_col        = cur_col;
      add_payload(c);
    end else if (is_punct(c)) begin
      tok_line = cur_line;
      tok_col  = cur_col;
      // may be the start of a pair, decided by the next char
      if (c == pair_a[15:8] || c == pair_b[15:8]) begin
        held_char = c;
        scan_mode = stt_pkg::MODE_PENDING;
      end else begin
        add_result(stt_pkg::KIND_SYMBOL, tok_line, tok_col, '0, 1'b0, c, '0, '0, 1'b0);
      end
    end else if (c == stt_pkg::CHAR_QUOTE) begin
      scan_mode = stt_pkg::MODE_STRING;
      tok_line  = cur_line;
      tok_col   = cur_col;
    end else if (is_alpha_char(c)) begin
      scan_mode = stt_pkg::MODE_IDENT;
      tok_line  = cur_line;
      tok_col   = cur_col;
      add_payload(c);
    end else if (c == stt_pkg::CHAR_SPACE || c == stt_pkg::CHAR_TAB) begin
      // whitespace only moves the column
    end else if (c == stt_pkg::CHAR_NEWLINE) begin
      is_newline = 1'b1;
    end else begin
      add_result(stt_pkg::KIND_ERROR, cur_line, cur_col, '0, 1'b0, '0, '0, '0,
                 stt_pkg::ERR_INVALID_CHAR);
      halted = 1'b1;
    end
  endtask

  // work out the results of one accepted item and queue them
  task automatic tokenize_item(logic [7:0] c, logic eos);
    logic        nl;
    logic [34:0] wide;
    step_results.delete();
    nl = 1'b0;
    if (eos) begin
      if (halted) begin
        halted = 1'b0;
      end else if (scan_mode == stt_pkg::MODE_STRING || scan_mode == stt_pkg::MODE_ESCAPE) begin
        // open string: error at its start, no end token
        add_result(stt_pkg::KIND_ERROR, tok_line, tok_col, '0, 1'b0, '0, '0, '0,
                   stt_pkg::ERR_UNTERMINATED);
      end else begin
        close_token();
        add_result(stt_pkg::KIND_END, cur_line, cur_col, '0, 1'b0, '0, '0, '0, 1'b0);
      end
      restart_scan();
    end else if (!halted) begin
      case (scan_mode)
        stt_pkg::MODE_NUMBER: begin
          if (c == stt_pkg::CHAR_DOT) begin
            dot_seen = 1'b1;
            add_payload(c);
          end else if (is_num_char(c)) begin
            wide = {4'b0, number_value} * 35'd10 + 35'(c - stt_pkg::CHAR_ZERO);
            if (wide > 35'(stt_pkg::VALUE_MAX)) begin
              number_value   = stt_pkg::VALUE_MAX;
              number_clamped = 1'b1;
            end else begin
              number_value = wide[30:0];
            end
            add_payload(c);
          end else begin
            close_token();
            scan_fresh(c, nl);
          end
        end
        stt_pkg::MODE_IDENT: begin
          // underscore continues an identifier
          if (is_alpha_char(c) || c == stt_pkg::CHAR_UNDERSCORE) begin
            add_payload(c);
          end else begin
            close_token();
            scan_fresh(c, nl);
          end
        end
        stt_pkg::MODE_PENDING: begin
          if ({held_char, c} == pair_a || {held_char, c} == pair_b) begin
            add_result(stt_pkg::KIND_SYMBOL, tok_line, tok_col, '0, 1'b0, held_char, c, '0,
                       1'b0);
            scan_mode = stt_pkg::MODE_IDLE;
          end else begin
            close_token();
            scan_fresh(c, nl);
          end
        end
        stt_pkg::MODE_STRING: begin
          if (c == stt_pkg::CHAR_QUOTE) begin
            add_result(stt_pkg::KIND_STRING, tok_line, tok_col, '0, 1'b0, '0, '0, '0, 1'b0);
            scan_mode = stt_pkg::MODE_IDLE;
          end else if (c == stt_pkg::CHAR_BACKSLASH) begin
            scan_mode = stt_pkg::MODE_ESCAPE;
          end else begin
            add_payload(c);
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          scan_mode = stt_pkg::MODE_STRING;
          if (c == stt_pkg::CHAR_LOWER_N) begin
            add_payload(stt_pkg::CHAR_NEWLINE);
          end else if (c == stt_pkg::CHAR_BACKSLASH || c == stt_pkg::CHAR_QUOTE) begin
            add_payload(c);
          end else begin
            // unknown escape keeps both chars
            add_payload(stt_pkg::CHAR_BACKSLASH);
            add_payload(c);
          end
        end
        default: scan_fresh(c, nl);
      endcase
      // a newline inside a string is text and only moves the column
      if (nl) begin
        cur_line = bump(cur_line);
        cur_col  = 16'd1;
      end else begin
        cur_col = bump(cur_col);
      end
    end
    if (step_results.size() != 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endtask

  // --------------------------------------------------------------------------
  // source text generation
  // --------------------------------------------------------------------------

  task automatic push_char(logic [7:0] c);
    source_feed.push_back({1'b0, c});
  endtask

  // the char of an end item is ignored, so it carries noise
  task automatic push_end();
    source_feed.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) != 0) ? c + "a" : c + "A";
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] random_symbol();
    return SYMBOL_CHARS[$urandom_range(0, SYMBOL_CHARS.len() - 1)];
  endfunction

  // mostly well-formed tokens with random content, some noise and broken input
  task automatic add_random_text(int budget);
    int first_len, pick, len, sub;
    first_len = source_feed.size();
    while (source_feed.size() - first_len < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        // integers, now and then long enough to clamp
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
        repeat (len) push_char(random_digit());
      end else if (pick < 26) begin
        push_char(random_digit());
        len = $urandom_range(1, 5);
        repeat (len)
          push_char(($urandom_range(0, 2) == 0) ? stt_pkg::CHAR_DOT : random_digit());
      end else if (pick < 42) begin
        push_char(random_letter());
        len = $urandom_range(0, 5);
        repeat (len)
          push_char(($urandom_range(0, 3) == 0) ? stt_pkg::CHAR_UNDERSCORE : random_letter());
      end else if (pick < 56) begin
        push_char(stt_pkg::CHAR_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          sub = $urandom_range(0, 9);
          if (sub < 3) begin
            push_char(stt_pkg::CHAR_BACKSLASH);
            case (sub)
              0:       push_char(stt_pkg::CHAR_LOWER_N);
              1:       push_char(($urandom_range(0, 1) != 0) ? stt_pkg::CHAR_BACKSLASH
                                                              : stt_pkg::CHAR_QUOTE);
              default: push_char(8'($urandom_range(0, 255)));
            endcase
          end else if (sub == 3) begin
            push_char(stt_pkg::CHAR_NEWLINE);
          end else begin
            push_char(8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 15) != 0) push_char(stt_pkg::CHAR_QUOTE);
      end else if (pick < 70) begin
        sub = $urandom_range(0, 5);
        case (sub)
          3: begin
            push_char(pair_a[15:8]);
            push_char(pair_a[7:0]);
          end
          4: begin
            push_char(pair_b[15:8]);
            push_char(pair_b[7:0]);
          end
          5: begin
            // held char that is not completed
            push_char(($urandom_range(0, 1) != 0) ? pair_a[15:8] : pair_b[15:8]);
            case ($urandom_range(0, 3))
              0:       push_char(random_symbol());
              1:       push_char(random_letter());
              2:       push_char(random_digit());
              default: push_char(stt_pkg::CHAR_SPACE);
            endcase
          end
          default: push_char(random_symbol());
        endcase
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       push_char(stt_pkg::CHAR_TAB);
          1:       push_char(stt_pkg::CHAR_NEWLINE);
          default: push_char(stt_pkg::CHAR_SPACE);
        endcase
      end else if (pick < 89) begin
        push_end();
      end else if (pick < 95) begin
        // raw byte, often invalid, so keep the halt short
        push_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) push_end();
      end else begin
        // string left open at the end of the source
        push_char(stt_pkg::CHAR_QUOTE);
        if ($urandom_range(0, 1) != 0) push_char(random_letter());
        if ($urandom_range(0, 1) != 0) push_char(stt_pkg::CHAR_BACKSLASH);
        push_end();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // source side driver: one item offered at a time, random gap bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic         took;
    source_item_t next_item;
    if (rst_n) begin
      took = src_valid && src_ready;
      if (took) begin
        tokenize_item(src_char, src_eos);
        items_taken <= items_taken + 1;
      end
      if (src_valid && !took) begin
        // hold the item until the block takes it
      end else if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        src_valid <= 1'b0;
      end else if (source_feed.size() != 0 && gaps_on && $urandom_range(0, 7) == 0) begin
        gap_left  <= $urandom_range(0, 2);
        src_valid <= 1'b0;
      end else if (source_feed.size() != 0) begin
        next_item = source_feed.pop_front();
        src_valid <= 1'b1;
        src_char  <= next_item.ch;
        src_eos   <= next_item.eos;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall bursts plus two long hold-offs that fill the
  // block and push back on the source stream
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if ((holds_done == 0 && items_taken >= 420) ||
                   (holds_done == 1 && items_taken >= 1180)) begin
        holds_done <= holds_done + 1;
        hold_left  <= LONG_HOLD - 1;
        res_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_ready  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 2);
        res_ready  <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor: compare with the oldest awaited result
  always @(posedge clk) begin
    token_result_t want;
    if (rst_n && res_valid && res_ready) begin
      results_taken++;
      kinds_seen[res_kind] = 1'b1;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d", $time, res_kind);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind",          32'(want.kind),    32'(res_kind));
        check_field("token_line",    32'(want.line),    32'(res_data[15:0]));
        check_field("token_column",  32'(want.column),  32'(res_data[31:16]));
        check_field("int_value",     32'(want.value),   32'(res_data[62:32]));
        check_field("int_saturated", 32'(want.clamped), 32'(res_data[63]));
        check_field("symbol_first",  32'(want.sym_a),   32'(res_data[71:64]));
        check_field("symbol_second", 32'(want.sym_b),   32'(res_data[79:72]));
        check_field("payload_char",  32'(want.text),    32'(res_data[87:80]));
        check_field("error_code",    32'(want.err),     32'(res_data[88]));
        check_field("zero fill",     32'h0,             32'(res_data[95:89]));
        check_field("last_of_run",   32'(want.last),    32'(res_last));
      end
    end
  end

  // watchdog: too long with no item moving on either side ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (src_valid && src_ready) || (res_valid && res_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no item moved for %0d cycles, %0d results still awaited",
             $time, STALL_LIMIT, awaited_results.size());
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // configuration access and phase control
  // --------------------------------------------------------------------------

  // write one pair register, then read it back
  task automatic write_pair(logic reg_idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == stt_pkg::REG_PAIR_FIRST) pair_a = value;
    else pair_b = value;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("pair register", {16'h0, value}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // every item sent and every result back, then room for items that give none
  task automatic wait_drained();
    while (source_feed.size() != 0 || src_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] first_pair, second_pair;
    pair_a = stt_pkg::PAIR_FIRST_RESET;
    pair_b = stt_pkg::PAIR_SECOND_RESET;
    halted = 1'b0;
    restart_scan();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening with the reset pairs, ending in an invalid char, a
    // char ignored while halted and the end item that restarts the block
    @(negedge clk);
    for (int i = 0; i < OPENING_TEXT.len(); i++) push_char(OPENING_TEXT[i]);
    push_char(8'h01);
    push_char("z");
    push_end();
    wait_drained();

    for (int s = 0; s < 7; s++) begin
      case (s)
        0: begin first_pair = 16'h3D3D; second_pair = 16'h3C3D; end  // "==", "<="
        1: begin first_pair = 16'h0000; second_pair = 16'hFFFF; end
        2: begin first_pair = 16'hFFFF; second_pair = 16'h0000; end
        3: begin first_pair = 16'h2D3E; second_pair = 16'h2D3D; end  // shared first char
        4: begin first_pair = 16'h210A; second_pair = 16'h3C61; end  // newline, letter
        5: begin
          first_pair  = {random_symbol(), 8'($urandom_range(0, 255))};
          second_pair = {random_symbol(), 8'($urandom_range(0, 255))};
        end
        default: begin
          first_pair  = stt_pkg::PAIR_FIRST_RESET;
          second_pair = stt_pkg::PAIR_SECOND_RESET;
        end
      endcase
      write_pair(stt_pkg::REG_PAIR_FIRST, first_pair);
      write_pair(stt_pkg::REG_PAIR_SECOND, second_pair);
      settings_used++;
      @(negedge clk);
      add_random_text(RANDOM_PER_SETTING);
      wait_drained();
    end

    // final stretch with no idling on either side
    @(negedge clk);
    gaps_on = 1'b0;
    add_random_text(CALM_ITEMS);
    push_end();
    wait_drained();
    @(negedge clk);

    $display("run covered %0d source items and %0d results over %0d pair settings",
             items_taken, results_taken, settings_used);
    $display("result kinds seen %08b, long hold-offs %0d", kinds_seen, holds_done);
    if (awaited_results.size() != 0)
      $display("%0d awaited results never arrived", awaited_results.size());
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/stt_pkg.sv
rtl/core/source_text_tokenizer_unit.sv
tb/sv/tb_top.sv
